// ===== rtl/core/prts_pkg.sv =====
// shared types and constants for the periodic task release scheduler
// no dependencies; every other file refers to it by scoped names
package prts_pkg;

   localparam int MAX_TASKS = 10;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SLOT_W    = 4;
   localparam int PERIOD_W  = 16;
   localparam int TICK_W    = 32;
   localparam int OPT_W     = 16;
   localparam int CMD_W     = 3;
   localparam int DIV_CNT_W = $clog2(TICK_W);

   // apb side
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_OVERFLOWS_PER_TICK = 1'b0
   } reg_index_type;

   typedef enum logic [CMD_W-1:0] {
      OP_OVERFLOW = 3'd0,
      OP_CREATE   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_RESUME   = 3'd3,
      OP_PAUSE    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_READY     = 2'd0,
      MODE_SUSPENDED = 2'd1,
      MODE_DELETED   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept_en;   // input channel open
      logic scan_init;   // new tick: point at top slot, clear due mask
      logic div_start;   // launch remainder for current slot
      logic mark_due;    // record remainder result for current slot
      logic idx_dec;     // move to next lower slot
      logic idx_reload;  // back to top slot for the emit walk
      logic emit;        // load current slot into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tick_done;   // offered word is an overflow that completes a tick
      logic eligible;    // current slot present, ready, nonzero period
      logic div_done;    // remainder finished this cycle
      logic idx_zero;    // current slot is slot 0
      logic mask_bit;    // current slot is due
      logic out_free;    // output register can take a word
   } ctrl_stat_type;

endpackage

// ===== rtl/core/periodic_task_release_scheduler.sv =====
// top level of the periodic task release scheduler: apb register decode,
// controller and datapath; depends on prts_pkg, prts_ctrl, prts_datapath
//
// Each request word is one command: an overflow event or an edit of one task
// slot (create, delete, resume, pause). Edits, and overflow events that do not
// complete a tick, yield no response word. An overflow that completes a tick
// bumps the 32-bit tick count and starts a scan: every slot is visited from the
// top index down; a slot that is present, ready and has a nonzero period goes
// through the serial remainder unit (tick count modulo period, one bit per
// cycle). A second walk then sends one response word per due slot, highest
// index first, with last set on the final one; a stalled consumer holds the
// walk. req_stall stays high for the whole scan; the response register lets the
// block take the next request while the final word still waits. The only
// register, overflows_per_tick at byte address 0, reloads the overflow
// countdown when written; write it only while the block is idle.
module periodic_task_release_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [prts_pkg::CMD_W-1:0]        req_cmd,
   input  logic [prts_pkg::SLOT_W-1:0]       req_slot,
   input  logic [prts_pkg::PERIOD_W-1:0]     req_period,
   input  logic                              req_has_handler,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [prts_pkg::SLOT_W-1:0]       rsp_due_slot,
   output logic [prts_pkg::TICK_W-1:0]       rsp_tick_value,
   output logic                              rsp_last,
   // apb register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [prts_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [prts_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [prts_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   prts_pkg::ctrl_cmd_type    cmd;
   prts_pkg::ctrl_stat_type   stat;
   prts_pkg::reg_index_type   reg_idx;
   logic                      cfg_write;
   logic [prts_pkg::OPT_W-1:0] cfg_opt;

   // register index from the word address
   assign reg_idx   = prts_pkg::reg_index_type'(paddr[prts_pkg::CSR_ADDR_W-1:2]);
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite
                      && (reg_idx == prts_pkg::REG_OVERFLOWS_PER_TICK);

   always_comb begin
      unique case (reg_idx)
         prts_pkg::REG_OVERFLOWS_PER_TICK: prdata = prts_pkg::CSR_DATA_W'(cfg_opt);
         default:                          prdata = '0;
      endcase
   end

   // request channel is open only between ticks
   assign req_stall = !cmd.accept_en;

   prts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   prts_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_has_handler (req_has_handler),
      .cfg_write       (cfg_write),
      .cfg_data        (pwdata[prts_pkg::OPT_W-1:0]),
      .cfg_opt         (cfg_opt),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_due_slot    (rsp_due_slot),
      .rsp_tick_value  (rsp_tick_value),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/core/prts_rem.sv =====
// serial remainder unit: tick count modulo a slot period, one bit a cycle
// depends on prts_pkg
module prts_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [prts_pkg::TICK_W-1:0]   dividend,
   input  logic [prts_pkg::PERIOD_W-1:0] divisor,
   output logic                          done,
   output logic                          rem_zero
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [prts_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [prts_pkg::TICK_W-1:0]       dvd_ff, dvd_in;
   logic [prts_pkg::PERIOD_W-1:0]     dsr_ff, dsr_in;
   logic [prts_pkg::PERIOD_W-1:0]     rem_ff, rem_in;
   logic [prts_pkg::PERIOD_W:0]       trial;
   logic [prts_pkg::PERIOD_W:0]       diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[prts_pkg::TICK_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // restoring step: partial remainder always stays below the divisor
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[prts_pkg::PERIOD_W-1:0];
         end else begin
            rem_in = trial[prts_pkg::PERIOD_W-1:0];
         end
         dvd_in = {dvd_ff[prts_pkg::TICK_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == prts_pkg::DIV_CNT_W'(prts_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/core/prts_datapath.sv =====
// slot table, tick counter, overflow countdown, due mask and output register
// depends on prts_pkg and prts_rem
module prts_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [prts_pkg::CMD_W-1:0]      req_cmd,
   input  logic [prts_pkg::SLOT_W-1:0]     req_slot,
   input  logic [prts_pkg::PERIOD_W-1:0]   req_period,
   input  logic                            req_has_handler,
   input  logic                            cfg_write,
   input  logic [prts_pkg::OPT_W-1:0]      cfg_data,
   output logic [prts_pkg::OPT_W-1:0]      cfg_opt,
   input  prts_pkg::ctrl_cmd_type          cmd,
   output prts_pkg::ctrl_stat_type         stat,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prts_pkg::SLOT_W-1:0]     rsp_due_slot,
   output logic [prts_pkg::TICK_W-1:0]     rsp_tick_value,
   output logic                            rsp_last
);

   logic [prts_pkg::OPT_W-1:0]     opt_ff, opt_in;
   logic [prts_pkg::OPT_W-1:0]     cdown_ff, cdown_in;
   logic [prts_pkg::OPT_W-1:0]     cdown_dec;
   logic [prts_pkg::TICK_W-1:0]    tick_ff, tick_in;

   logic [prts_pkg::PERIOD_W-1:0]  period_ff  [prts_pkg::MAX_TASKS];
   logic                           present_ff [prts_pkg::MAX_TASKS];
   prts_pkg::mode_type             mode_ff    [prts_pkg::MAX_TASKS];

   logic [prts_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [prts_pkg::MAX_TASKS-1:0] mask_ff, mask_in;

   logic                           rvalid_ff, rvalid_in;
   logic [prts_pkg::SLOT_W-1:0]    rslot_ff;
   logic [prts_pkg::TICK_W-1:0]    rtick_ff;
   logic                           rlast_ff;

   logic                           accept;
   logic                           slot_ok;
   logic [prts_pkg::IDX_W-1:0]     wr_idx;
   logic                           any_lower;
   logic                           div_done;
   logic                           rem_zero;

   assign accept    = req_valid && cmd.accept_en;
   assign cdown_dec = cdown_ff - 1'b1;
   assign slot_ok   = ({1'b0, req_slot} < (prts_pkg::SLOT_W + 1)'(prts_pkg::MAX_TASKS));
   assign wr_idx    = req_slot[prts_pkg::IDX_W-1:0];

   // countdown, tick counter and the single config register
   always_comb begin
      opt_in   = opt_ff;
      cdown_in = cdown_ff;
      tick_in  = tick_ff;
      if (cfg_write) begin
         opt_in   = cfg_data;
         cdown_in = cfg_data;
      end else if (accept && (req_cmd == prts_pkg::OP_OVERFLOW)) begin
         if (cdown_dec == '0) begin
            cdown_in = opt_ff;
            tick_in  = tick_ff + 1'b1;
         end else begin
            cdown_in = cdown_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opt_ff   <= prts_pkg::OPT_W'(1);
         cdown_ff <= prts_pkg::OPT_W'(1);
         tick_ff  <= '0;
      end else begin
         opt_ff   <= opt_in;
         cdown_ff <= cdown_in;
         tick_ff  <= tick_in;
      end
   end

   // slot table edits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < prts_pkg::MAX_TASKS; i++) begin
            period_ff[i]  <= '0;
            present_ff[i] <= 1'b0;
            mode_ff[i]    <= prts_pkg::MODE_READY;
         end
      end else if (accept && slot_ok) begin
         case (req_cmd)
            prts_pkg::OP_CREATE: begin
               present_ff[wr_idx] <= req_has_handler;
               period_ff[wr_idx]  <= req_period;
               mode_ff[wr_idx]    <= prts_pkg::MODE_READY;
            end
            prts_pkg::OP_DELETE: begin
               mode_ff[wr_idx]    <= prts_pkg::MODE_DELETED;
               present_ff[wr_idx] <= 1'b0;
            end
            prts_pkg::OP_RESUME: begin
               mode_ff[wr_idx] <= prts_pkg::MODE_READY;
            end
            prts_pkg::OP_PAUSE: begin
               mode_ff[wr_idx] <= prts_pkg::MODE_SUSPENDED;
            end
            default: begin
            end
         endcase
      end
   end

   prts_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (tick_ff),
      .divisor  (period_ff[idx_ff]),
      .done     (div_done),
      .rem_zero (rem_zero)
   );

   // scan pointer and due mask
   always_comb begin
      idx_in  = idx_ff;
      mask_in = mask_ff;
      if (cmd.scan_init || cmd.idx_reload) begin
         idx_in = prts_pkg::IDX_W'(prts_pkg::MAX_TASKS - 1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end
      if (cmd.scan_init) begin
         mask_in = '0;
      end else if (cmd.mark_due) begin
         mask_in[idx_ff] = rem_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         mask_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         mask_ff <= mask_in;
      end
   end

   // nothing due below the current slot means this word closes the tick
   always_comb begin
      any_lower = 1'b0;
      for (int j = 0; j < prts_pkg::MAX_TASKS; j++) begin
         if ((j < int'(idx_ff)) && mask_ff[j]) begin
            any_lower = 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rvalid_in = rvalid_ff;
      if (cmd.emit) begin
         rvalid_in = 1'b1;
      end else if (!rsp_stall) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rslot_ff <= prts_pkg::SLOT_W'(idx_ff);
         rtick_ff <= tick_ff;
         rlast_ff <= !any_lower;
      end
   end

   always_comb begin
      stat.tick_done = req_valid && (req_cmd == prts_pkg::OP_OVERFLOW)
                       && (cdown_dec == '0);
      stat.eligible  = present_ff[idx_ff] && (mode_ff[idx_ff] == prts_pkg::MODE_READY)
                       && (period_ff[idx_ff] != '0);
      stat.div_done  = div_done;
      stat.idx_zero  = (idx_ff == '0);
      stat.mask_bit  = mask_ff[idx_ff];
      stat.out_free  = !rvalid_ff || !rsp_stall;
   end

   assign cfg_opt        = opt_ff;
   assign rsp_valid      = rvalid_ff;
   assign rsp_due_slot   = rslot_ff;
   assign rsp_tick_value = rtick_ff;
   assign rsp_last       = rlast_ff;

endmodule

// ===== rtl/core/prts_ctrl.sv =====
// controller state machine: tick scan over the slots, then the emit walk
// depends on prts_pkg
module prts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  prts_pkg::ctrl_stat_type stat,
   output prts_pkg::ctrl_cmd_type  cmd
);

   prts_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prts_pkg::ST_IDLE: begin
            if (req_valid && stat.tick_done) begin
               state_in = prts_pkg::ST_CHECK;
            end
         end
         prts_pkg::ST_CHECK: begin
            if (stat.eligible) begin
               state_in = prts_pkg::ST_DIV;
            end else if (stat.idx_zero) begin
               state_in = prts_pkg::ST_EMIT;
            end
         end
         prts_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = stat.idx_zero ? prts_pkg::ST_EMIT : prts_pkg::ST_CHECK;
            end
         end
         prts_pkg::ST_EMIT: begin
            if (stat.idx_zero && (!stat.mask_bit || stat.out_free)) begin
               state_in = prts_pkg::ST_IDLE;
            end
         end
         default: state_in = prts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         prts_pkg::ST_IDLE: begin
            cmd.accept_en = 1'b1;
            cmd.scan_init = req_valid && stat.tick_done;
         end
         prts_pkg::ST_CHECK: begin
            cmd.div_start  = stat.eligible;
            cmd.idx_dec    = !stat.eligible && !stat.idx_zero;
            cmd.idx_reload = !stat.eligible && stat.idx_zero;
         end
         prts_pkg::ST_DIV: begin
            cmd.mark_due   = stat.div_done;
            cmd.idx_dec    = stat.div_done && !stat.idx_zero;
            cmd.idx_reload = stat.div_done && stat.idx_zero;
         end
         prts_pkg::ST_EMIT: begin
            cmd.emit    = stat.mask_bit && stat.out_free;
            cmd.idx_dec = !stat.idx_zero && (!stat.mask_bit || stat.out_free);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/prts_checker.sv =====
// port-level checks for the periodic task release scheduler, bound to the top
// depends on prts_pkg and periodic_task_release_scheduler
module prts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [prts_pkg::SLOT_W-1:0]   rsp_due_slot,
   input logic [prts_pkg::TICK_W-1:0]   rsp_tick_value,
   input logic                          rsp_last
);

   // the block comes out of reset ready for a word and with nothing to send
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!req_stall && !rsp_valid))
      else $error("not idle after reset");

   // a word that does not close its tick means the emit walk is still running
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request taken before tick fully released");

   // released slot index lies inside the table
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_due_slot} < (prts_pkg::SLOT_W + 1)'(prts_pkg::MAX_TASKS)))
      else $error("released slot out of range");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_due_slot)
         && $stable(rsp_tick_value) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind periodic_task_release_scheduler prts_checker u_prts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_due_slot   (rsp_due_slot),
   .rsp_tick_value (rsp_tick_value),
   .rsp_last       (rsp_last)
);

// ===== tb/sv/tb_periodic_task_release_scheduler.sv =====
// testbench for the periodic task release scheduler: directed and random command words,
// a self-checking scoreboard and apb writes of the tick length
// depends on prts_pkg and periodic_task_release_scheduler
`timescale 1ns / 100ps

module tb_periodic_task_release_scheduler;

   // one expected release word
   typedef struct {
      logic [prts_pkg::SLOT_W-1:0] slot;
      logic [prts_pkg::TICK_W-1:0] tick;
      logic                        last;
   } release_word_type;

   // scoreboard: own copy of the slot table and tick counter, queue of pending releases
   class release_scoreboard;
      logic [15:0]        ovf_per_tick;
      logic [15:0]        ovf_left;
      logic [31:0]        tick_count;
      logic [15:0]        period_tab [prts_pkg::MAX_TASKS];
      bit                 present_tab [prts_pkg::MAX_TASKS];
      prts_pkg::mode_type mode_tab [prts_pkg::MAX_TASKS];
      release_word_type   release_q[$];
      int                 errors;

      function new();
         ovf_per_tick = 16'd1;
         ovf_left     = 16'd1;
         tick_count   = '0;
         errors       = 0;
         for (int i = 0; i < prts_pkg::MAX_TASKS; i++) begin
            period_tab[i]  = '0;
            present_tab[i] = 1'b0;
            mode_tab[i]    = prts_pkg::MODE_READY;
         end
      endfunction

      // a register write also reloads the countdown
      function void set_overflows(logic [15:0] value);
         ovf_per_tick = value;
         ovf_left     = value;
      endfunction

      function bit slot_due(int s);
         if (!present_tab[s] || mode_tab[s] != prts_pkg::MODE_READY || period_tab[s] == 16'd0)
            return 1'b0;
         return (tick_count % {16'd0, period_tab[s]}) == 32'd0;
      endfunction

      function void note_request(logic [2:0] cmd, logic [3:0] slot, logic [15:0] period,
                                 logic handler);
         release_word_type w;
         int lowest;
         if (cmd == prts_pkg::OP_OVERFLOW) begin
            ovf_left = ovf_left - 16'd1;
            if (ovf_left == 16'd0) begin
               ovf_left   = ovf_per_tick;
               tick_count = tick_count + 32'd1;
               lowest = -1;
               for (int s = prts_pkg::MAX_TASKS - 1; s >= 0; s--)
                  if (slot_due(s)) lowest = s;
               for (int s = prts_pkg::MAX_TASKS - 1; s >= 0; s--)
                  if (slot_due(s)) begin
                     w.slot = 4'(s);
                     w.tick = tick_count;
                     w.last = (s == lowest);
                     release_q.push_back(w);
                  end
            end
         end else if (slot < prts_pkg::MAX_TASKS) begin
            case (cmd)
               prts_pkg::OP_CREATE: begin
                  present_tab[slot] = handler;
                  period_tab[slot]  = period;
                  mode_tab[slot]    = prts_pkg::MODE_READY;
               end
               prts_pkg::OP_DELETE: begin
                  mode_tab[slot]    = prts_pkg::MODE_DELETED;
                  present_tab[slot] = 1'b0;
               end
               prts_pkg::OP_RESUME: mode_tab[slot] = prts_pkg::MODE_READY;
               prts_pkg::OP_PAUSE:  mode_tab[slot] = prts_pkg::MODE_SUSPENDED;
               default: ;
            endcase
         end
      endfunction

      function void check_release(logic [3:0] slot, logic [31:0] tick, logic last);
         release_word_type w;
         if (release_q.size() == 0) begin
            $display("%0t: unexpected release word slot %0d tick %0d last %0d",
                     $time, slot, tick, last);
            errors++;
            return;
         end
         w = release_q.pop_front();
         if (w.slot !== slot) begin
            $display("%0t: due_slot expected %0d actual %0d", $time, w.slot, slot);
            errors++;
         end
         if (w.tick !== tick) begin
            $display("%0t: tick_value expected %0d actual %0d", $time, w.tick, tick);
            errors++;
         end
         if (w.last !== last) begin
            $display("%0t: last expected %0d actual %0d", $time, w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [prts_pkg::CMD_W-1:0]        req_cmd = '0;
   logic [prts_pkg::SLOT_W-1:0]       req_slot = '0;
   logic [prts_pkg::PERIOD_W-1:0]     req_period = '0;
   logic                              req_has_handler = 1'b0;

   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [prts_pkg::SLOT_W-1:0]       rsp_due_slot;
   logic [prts_pkg::TICK_W-1:0]       rsp_tick_value;
   logic                              rsp_last;

   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [prts_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [prts_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   logic [prts_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   release_scoreboard sb;

   // sender gaps forced to zero while set
   bit tx_quiet = 1'b0;
   // one long receiver hold-off, asked for by the main sequence
   bit hold_wanted = 1'b0;
   bit hold_taken  = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   periodic_task_release_scheduler uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_has_handler (req_has_handler),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_due_slot    (rsp_due_slot),
      .rsp_tick_value  (rsp_tick_value),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // offer one command word after a random gap; returns at the edge that took it,
   // so the next call drives valid exactly once in that time step
   task automatic send_word(input logic [2:0] cmd, input logic [3:0] slot,
                            input logic [15:0] period, input logic handler);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_slot        <= slot;
      req_period      <= period;
      req_has_handler <= handler;
      // values read right after the edge are the ones the block saw at it
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, slot, period, handler);
   endtask

   // drop valid, drain every pending release, then cover a full silent scan
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.release_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // apb write of the tick length, then a read back of the same register
   task automatic set_tick_length(input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {prts_pkg::REG_OVERFLOWS_PER_TICK, 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // write lands at this edge
      sb.set_overflows(value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {16'd0, value}) begin
         $display("%0t: prdata expected %h actual %h", $time, {16'd0, value}, prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // random command mix: overflow-heavy so ticks keep coming, with slot edits,
   // out of range slots, zero and wide periods and unknown commands mixed in
   task automatic random_items(input int count);
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [15:0] period;
      logic        handler;
      int          pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
         pick = $urandom_range(0, 99);
         if (pick < 58)      cmd = prts_pkg::OP_OVERFLOW;
         else if (pick < 72) cmd = prts_pkg::OP_CREATE;
         else if (pick < 80) cmd = prts_pkg::OP_DELETE;
         else if (pick < 88) cmd = prts_pkg::OP_RESUME;
         else if (pick < 96) cmd = prts_pkg::OP_PAUSE;
         else                cmd = 3'($urandom_range(5, 7));
         slot = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
         case ($urandom_range(0, 9))
            0:       period = 16'd0;
            1:       period = 16'($urandom);
            default: period = 16'($urandom_range(1, 12));
         endcase
         handler = ($urandom_range(0, 7) != 0);
         send_word(cmd, slot, period, handler);
      end
      tx_quiet = 1'b0;
   endtask

   // receiver: random stall per word, quiet stretches, and one long hold-off
   // so the response register fills and the block backs up its input
   initial begin
      int gap;
      bit quiet;
      quiet = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) quiet = !quiet;
         gap = quiet ? 0 : $urandom_range(0, 17);
         if (hold_wanted && !hold_taken) begin
            gap = 900;
            hold_taken = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_release(rsp_due_slot, rsp_tick_value, rsp_last);
      end
   end

   // main sequence
   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: creates incl. zero period, absent handler and out of range slot
      send_word(prts_pkg::OP_CREATE, 4'd9, 16'd1, 1'b1);
      send_word(prts_pkg::OP_CREATE, 4'd0, 16'hFFFF, 1'b1);
      send_word(prts_pkg::OP_CREATE, 4'd5, 16'd2, 1'b1);
      send_word(prts_pkg::OP_CREATE, 4'd3, 16'd0, 1'b1);
      send_word(prts_pkg::OP_CREATE, 4'd7, 16'd3, 1'b0);
      send_word(prts_pkg::OP_CREATE, 4'd12, 16'd1, 1'b1);
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      send_word(prts_pkg::OP_OVERFLOW, 4'hF, 16'hFFFF, 1'b1);
      send_word(prts_pkg::OP_PAUSE, 4'd5, 16'd0, 1'b0);
      // unknown command, all ones in every field
      send_word(3'd7, 4'hF, 16'hFFFF, 1'b1);
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      send_word(prts_pkg::OP_RESUME, 4'd5, 16'd0, 1'b0);
      send_word(prts_pkg::OP_DELETE, 4'd9, 16'd0, 1'b0);
      // resume after delete: ready again but still absent
      send_word(prts_pkg::OP_RESUME, 4'd9, 16'd0, 1'b0);
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      send_word(prts_pkg::OP_DELETE, 4'd15, 16'd0, 1'b0);
      send_word(prts_pkg::OP_PAUSE, 4'd10, 16'd0, 1'b0);
      send_word(prts_pkg::OP_RESUME, 4'd14, 16'd0, 1'b0);
      send_word(prts_pkg::OP_CREATE, 4'd8, 16'd4, 1'b1);
      send_word(3'd5, 4'd8, 16'd1, 1'b1);
      send_word(3'd6, 4'd0, 16'd2, 1'b0);
      // tick 5 releases nothing, then ticks 6 to 8
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      settle();

      set_tick_length(16'd3);
      random_items(120);
      settle();

      // one tick per overflow, with the long receiver hold-off early on
      set_tick_length(16'd1);
      hold_wanted = 1'b1;
      random_items(170);
      settle();

      // widest tick length: overflows never complete a tick here
      set_tick_length(16'hFFFF);
      random_items(24);
      settle();

      set_tick_length(16'd2);
      random_items(100);
      settle();

      // zero tick length: countdown wraps, so a short run of overflows
      // completes no tick
      set_tick_length(16'd0);
      send_word(prts_pkg::OP_CREATE, 4'd6, 16'd1, 1'b1);
      tx_quiet = 1'b1;
      repeat (20) send_word(prts_pkg::OP_OVERFLOW, 4'd0, 16'd0, 1'b0);
      tx_quiet = 1'b0;
      settle();

      set_tick_length(16'd1);
      random_items(20);
      settle();

      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #15000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
